FILE: rtl/core/uos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uos_pkg
// Shared types, constants and tables for the unicycle odometry step block.
// ----------------------------------------------------------------------------
package uos_pkg;

    localparam int PI_Q13     = 25736;
    localparam int TWO_PI_Q13 = 51472;
    localparam int PI_A       = 205888;
    localparam int HALF_PI_A  = 102944;
    localparam int TWO_PI_A   = 411776;
    localparam int CORDIC_K   = 652032874;
    localparam int CORDIC_N   = 16;
    localparam int DIV_STEPS  = 1;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_BASE   = 1000;
    localparam int DIV_RECIP  = 1099511628;
    localparam int DIV_SHIFT  = 40;

    typedef enum logic [2:0] {
        CFG_STEP_MS    = 3'd0,
        CFG_ACCEL      = 3'd1,
        CFG_ANG_ACCEL  = 3'd2,
        CFG_SPEED_LIM  = 3'd3,
        CFG_TURN_LIM   = 3'd4,
        CFG_MDIST      = 3'd5,
        CFG_MHEAD      = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD,
        OP_DIV_LIMV, OP_DIV_LIMW, OP_DIV_DTH, OP_DIV_DXY, OP_DIV_STEP,
        OP_SET_V, OP_SET_W, OP_SET_DTH, OP_SET_DXY,
        OP_CORD_MID, OP_CORD_MARK, OP_CORD_STEP,
        OP_MUL_XC, OP_MUL_YS, OP_MUL_MXC, OP_MUL_MYS, OP_MUL_AX, OP_MUL_AY,
        OP_POSX, OP_POSY, OP_MX, OP_MY,
        OP_DIFF, OP_SQX, OP_SQ_SUM, OP_SQRT_STEP, OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic started;
        logic marker_ready;
        logic div_done;
        logic cord_done;
        logic sqrt_done;
        logic out_busy;
    } dp_status_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_LIMV, S_LIMV_RUN, S_SETV,
        S_LIMW, S_LIMW_RUN, S_SETW,
        S_DTH, S_DTH_RUN, S_SETDTH,
        S_DXY, S_DXY_RUN, S_SETDXY,
        S_CMID, S_CMID_RUN, S_MXC, S_POSX, S_MYS, S_POSY,
        S_CMARK, S_CMARK_RUN, S_MMXC, S_MX, S_MMYS, S_MY,
        S_DIFF, S_MAX, S_SQX, S_MAY, S_SQSUM, S_SQRT_RUN,
        S_COMMIT
    } ctrl_state_t;

    function automatic logic [15:0] atan_val(input logic [3:0] i);
        logic [15:0] r;
        case (i)
            4'd0:    r = 16'd51472;
            4'd1:    r = 16'd30386;
            4'd2:    r = 16'd16055;
            4'd3:    r = 16'd8150;
            4'd4:    r = 16'd4091;
            4'd5:    r = 16'd2047;
            4'd6:    r = 16'd1024;
            4'd7:    r = 16'd512;
            4'd8:    r = 16'd256;
            4'd9:    r = 16'd128;
            4'd10:   r = 16'd64;
            4'd11:   r = 16'd32;
            4'd12:   r = 16'd16;
            4'd13:   r = 16'd8;
            4'd14:   r = 16'd4;
            default: r = 16'd2;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/uos_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uos_ctrl
// Sequencer that steps the datapath through one odometry update.
// ----------------------------------------------------------------------------
module uos_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire uos_pkg::dp_status_t  status,
    output uos_pkg::dp_cmd_t          cmd
);
    import uos_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (in_valid && status.started) state_next = S_LIMV;
            S_LIMV:      state_next = S_LIMV_RUN;
            S_LIMV_RUN:  if (status.div_done) state_next = S_SETV;
            S_SETV:      state_next = S_LIMW;
            S_LIMW:      state_next = S_LIMW_RUN;
            S_LIMW_RUN:  if (status.div_done) state_next = S_SETW;
            S_SETW:      state_next = S_DTH;
            S_DTH:       state_next = S_DTH_RUN;
            S_DTH_RUN:   if (status.div_done) state_next = S_SETDTH;
            S_SETDTH:    state_next = S_DXY;
            S_DXY:       state_next = S_DXY_RUN;
            S_DXY_RUN:   if (status.div_done) state_next = S_SETDXY;
            S_SETDXY:    state_next = S_CMID;
            S_CMID:      state_next = S_CMID_RUN;
            S_CMID_RUN:  if (status.cord_done) state_next = S_MXC;
            S_MXC:       state_next = S_POSX;
            S_POSX:      state_next = S_MYS;
            S_MYS:       state_next = S_POSY;
            S_POSY:      state_next = S_CMARK;
            S_CMARK:     state_next = S_CMARK_RUN;
            S_CMARK_RUN: if (status.cord_done) state_next = S_MMXC;
            S_MMXC:      state_next = S_MX;
            S_MX:        state_next = S_MMYS;
            S_MMYS:      state_next = S_MY;
            S_MY:        state_next = status.marker_ready ? S_DIFF : S_COMMIT;
            S_DIFF:      state_next = S_MAX;
            S_MAX:       state_next = S_SQX;
            S_SQX:       state_next = S_MAY;
            S_MAY:       state_next = S_SQSUM;
            S_SQSUM:     state_next = S_SQRT_RUN;
            S_SQRT_RUN:  if (status.sqrt_done) state_next = S_COMMIT;
            S_COMMIT:    if (!status.out_busy) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:      if (in_valid) cmd.op = OP_LOAD;
            S_LIMV:      cmd.op = OP_DIV_LIMV;
            S_LIMW:      cmd.op = OP_DIV_LIMW;
            S_DTH:       cmd.op = OP_DIV_DTH;
            S_DXY:       cmd.op = OP_DIV_DXY;
            S_LIMV_RUN, S_LIMW_RUN, S_DTH_RUN, S_DXY_RUN:
                         cmd.op = status.div_done ? OP_NONE : OP_DIV_STEP;
            S_SETV:      cmd.op = OP_SET_V;
            S_SETW:      cmd.op = OP_SET_W;
            S_SETDTH:    cmd.op = OP_SET_DTH;
            S_SETDXY:    cmd.op = OP_SET_DXY;
            S_CMID:      cmd.op = OP_CORD_MID;
            S_CMARK:     cmd.op = OP_CORD_MARK;
            S_CMID_RUN, S_CMARK_RUN:
                         cmd.op = status.cord_done ? OP_NONE : OP_CORD_STEP;
            S_MXC:       cmd.op = OP_MUL_XC;
            S_POSX:      cmd.op = OP_POSX;
            S_MYS:       cmd.op = OP_MUL_YS;
            S_POSY:      cmd.op = OP_POSY;
            S_MMXC:      cmd.op = OP_MUL_MXC;
            S_MX:        cmd.op = OP_MX;
            S_MMYS:      cmd.op = OP_MUL_MYS;
            S_MY:        cmd.op = OP_MY;
            S_DIFF:      cmd.op = OP_DIFF;
            S_MAX:       cmd.op = OP_MUL_AX;
            S_SQX:       cmd.op = OP_SQX;
            S_MAY:       cmd.op = OP_MUL_AY;
            S_SQSUM:     cmd.op = OP_SQ_SUM;
            S_SQRT_RUN:  cmd.op = status.sqrt_done ? OP_NONE : OP_SQRT_STEP;
            S_COMMIT:    cmd.op = status.out_busy ? OP_NONE : OP_COMMIT;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/uos_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uos_datapath
// Configuration, state, divider, CORDIC, multiplier and square root units.
// ----------------------------------------------------------------------------
module uos_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire uos_pkg::dp_cmd_t     cmd,
    output uos_pkg::dp_status_t       status,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic signed [15:0]   cmd_speed,
    input  wire logic signed [15:0]   cmd_turn,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic signed [31:0]        pos_x,
    output logic signed [31:0]        pos_y,
    output logic signed [15:0]        heading_out,
    output logic signed [15:0]        speed_out,
    output logic signed [15:0]        turn_out,
    output logic signed [31:0]        marker_x_out,
    output logic signed [31:0]        marker_y_out,
    output logic [31:0]               path_dist_out,
    output logic                      anchor
);
    import uos_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -35'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    logic [9:0]  step_ms_reg;
    logic [14:0] accel_reg, ang_accel_reg, speed_lim_reg, turn_lim_reg, mdist_reg;
    logic [15:0] mhead_reg;

    logic               started_reg, marker_ready_reg, out_valid_reg, anchor_reg;
    logic signed [15:0] speed_reg, turn_reg, heading_reg;
    logic signed [31:0] posx_reg, posy_reg, mkx_reg, mky_reg;
    logic [31:0]        path_reg;
    logic [5:0]         cnt_reg;

    logic signed [15:0] cmd_v_reg, cmd_w_reg, v_new_reg, w_new_reg, th_new_reg;
    logic signed [17:0] dth_reg;
    logic signed [20:0] dxy_reg;
    logic signed [31:0] posx_new_reg, posy_new_reg, mx_reg, my_reg;
    logic [31:0]        dq_reg;
    logic               neg_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [19:0] cz_reg;
    logic               flip_reg;
    logic signed [63:0] prod_reg;
    logic [30:0]        ax_reg, ay_reg;
    logic               halve_reg;
    logic [62:0]        sq_reg;
    logic [63:0]        sv_reg, sr_reg, sbit_reg;

    dp_op_t op;
    assign op = cmd.op;

    // Divider numerator.
    logic signed [17:0] wsum, vsum;
    logic signed [32:0] num_s, num_mag;
    logic [31:0]        num_u;
    assign wsum = 18'(turn_reg) + 18'(w_new_reg);
    assign vsum = 18'(speed_reg) + 18'(v_new_reg);

    always_comb
    begin
        case (op)
            OP_DIV_LIMV: num_s = $signed(33'(accel_reg) * 33'(step_ms_reg));
            OP_DIV_LIMW: num_s = $signed(33'(ang_accel_reg) * 33'(step_ms_reg));
            OP_DIV_DTH:  num_s = 33'(wsum) * $signed(33'(step_ms_reg));
            default:     num_s = 33'(vsum) * $signed(33'({step_ms_reg, 3'b000}));
        endcase
        num_mag = num_s[32] ? -num_s : num_s;
        num_u   = num_mag[31:0] + 32'(DIV_BASE / 2);
    end

    // Division by 1000 through a reciprocal multiplication, exact below 2^30.
    logic [60:0]        div_prod;
    logic signed [32:0] quot_s;
    assign div_prod = {31'd0, dq_reg[29:0]} * {30'd0, 31'(DIV_RECIP)};
    assign quot_s   = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});

    // Rate limiting and clamping.
    logic signed [17:0] limq, vd, vdc, vs, vlim;
    logic signed [17:0] wd, wdc, ws, wlim;
    logic signed [15:0] v_next, w_next;
    always_comb
    begin
        limq = $signed({1'b0, dq_reg[16:0]});
        vd   = 18'(cmd_v_reg) - 18'(speed_reg);
        vdc  = (vd > limq) ? limq : ((vd < -limq) ? -limq : vd);
        vs   = 18'(speed_reg) + vdc;
        vlim = $signed({3'b000, speed_lim_reg});
        v_next = 16'((vs > vlim) ? vlim : ((vs < -vlim) ? -vlim : vs));
        wd   = 18'(cmd_w_reg) - 18'(turn_reg);
        wdc  = (wd > limq) ? limq : ((wd < -limq) ? -limq : wd);
        ws   = 18'(turn_reg) + wdc;
        wlim = $signed({3'b000, turn_lim_reg});
        w_next = 16'((ws > wlim) ? wlim : ((ws < -wlim) ? -wlim : ws));
    end

    // Heading integration and wrap.
    logic signed [17:0] dth_next;
    logic signed [19:0] th_sum;
    logic signed [15:0] th_next;
    always_comb
    begin
        dth_next = quot_s[17:0];
        th_sum   = 20'(heading_reg) + 20'(dth_next);
        for (int k = 0; k < 3; k++)
        begin
            if (th_sum > 20'(PI_Q13))
                th_sum = th_sum - 20'(TWO_PI_Q13);
            else if (th_sum <= -20'(PI_Q13))
                th_sum = th_sum + 20'(TWO_PI_Q13);
        end
        th_next = th_sum[15:0];
    end

    // CORDIC start angle.
    logic signed [22:0] ang;
    logic signed [19:0] z_init;
    logic               flip_init;
    always_comb
    begin
        if (op == OP_CORD_MID)
            ang = (23'(heading_reg) <<< 3) + (23'(dth_reg) <<< 2);
        else
            ang = (23'(th_new_reg) + 23'($signed(mhead_reg))) <<< 3;
        for (int k = 0; k < 3; k++)
        begin
            if (ang > 23'(PI_A))
                ang = ang - 23'(TWO_PI_A);
            else if (ang <= -23'(PI_A))
                ang = ang + 23'(TWO_PI_A);
        end
        flip_init = 1'b0;
        if (ang > 23'(HALF_PI_A))
        begin
            ang = ang - 23'(PI_A);
            flip_init = 1'b1;
        end
        else if (ang < -23'(HALF_PI_A))
        begin
            ang = ang + 23'(PI_A);
            flip_init = 1'b1;
        end
        z_init = ang[19:0];
    end

    logic signed [33:0] cx_sh, cy_sh, cos_v, sin_v;
    logic signed [19:0] at_v;
    assign cx_sh = cx_reg >>> cnt_reg[3:0];
    assign cy_sh = cy_reg >>> cnt_reg[3:0];
    assign at_v  = $signed({4'b0000, atan_val(cnt_reg[3:0])});
    assign cos_v = flip_reg ? -cx_reg : cx_reg;
    assign sin_v = flip_reg ? -cy_reg : cy_reg;

    // Shared multiplier.
    logic signed [33:0] ma, mb;
    always_comb
    begin
        case (op)
            OP_MUL_XC:  begin ma = 34'(dxy_reg); mb = cos_v; end
            OP_MUL_YS:  begin ma = 34'(dxy_reg); mb = sin_v; end
            OP_MUL_MXC: begin ma = $signed({15'd0, mdist_reg, 4'b0000}); mb = cos_v; end
            OP_MUL_MYS: begin ma = $signed({15'd0, mdist_reg, 4'b0000}); mb = sin_v; end
            OP_MUL_AX:  begin ma = $signed({3'b000, ax_reg}); mb = ma; end
            default:    begin ma = $signed({3'b000, ay_reg}); mb = ma; end
        endcase
    end

    logic signed [63:0] prod_rnd;
    logic signed [33:0] mq30;
    assign prod_rnd = (prod_reg + 64'sd536870912) >>> 30;
    assign mq30     = prod_rnd[33:0];

    logic signed [32:0] dx, dy;
    logic [32:0]        adx, ady;
    logic               big;
    assign dx  = 33'(mx_reg) - 33'(mkx_reg);
    assign dy  = 33'(my_reg) - 33'(mky_reg);
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);
    assign ady = dy[32] ? 33'(-dy) : 33'(dy);
    assign big = adx[32] | adx[31] | ady[32] | ady[31];

    logic [63:0] s_trial;
    logic [32:0] step_len;
    logic [33:0] path_sum;
    logic [31:0] path_next;
    assign s_trial   = sr_reg + sbit_reg;
    assign step_len  = halve_reg ? {sr_reg[31:0], 1'b0} : {1'b0, sr_reg[31:0]};
    assign path_sum  = {2'b00, path_reg} + {1'b0, step_len};
    assign path_next = path_sum[33:32] != 2'b00 ? 32'hFFFF_FFFF : path_sum[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ms_reg      <= 10'd100;
            accel_reg        <= 15'd1229;
            ang_accel_reg    <= 15'd6144;
            speed_lim_reg    <= 15'd3072;
            turn_lim_reg     <= 15'd4096;
            mdist_reg        <= 15'd0;
            mhead_reg        <= 16'd0;
            started_reg      <= 1'b0;
            marker_ready_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            anchor_reg       <= 1'b0;
            speed_reg        <= '0;
            turn_reg         <= '0;
            heading_reg      <= '0;
            posx_reg         <= '0;
            posy_reg         <= '0;
            mkx_reg          <= '0;
            mky_reg          <= '0;
            path_reg         <= '0;
            cnt_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_STEP_MS:   step_ms_reg   <= cfg_data[9:0];
                    CFG_ACCEL:     accel_reg     <= cfg_data[14:0];
                    CFG_ANG_ACCEL: ang_accel_reg <= cfg_data[14:0];
                    CFG_SPEED_LIM: speed_lim_reg <= cfg_data[14:0];
                    CFG_TURN_LIM:  turn_lim_reg  <= cfg_data[14:0];
                    CFG_MDIST:     mdist_reg     <= cfg_data[14:0];
                    CFG_MHEAD:     mhead_reg     <= cfg_data;
                    default:       ;
                endcase
            end
            if (out_valid_reg && !out_stall && op != OP_COMMIT)
                out_valid_reg <= 1'b0;
            case (op)
                OP_LOAD:
                    started_reg <= 1'b1;
                OP_DIV_LIMV, OP_DIV_LIMW, OP_DIV_DTH, OP_DIV_DXY,
                OP_CORD_MID, OP_CORD_MARK, OP_SQ_SUM:
                    cnt_reg <= '0;
                OP_DIV_STEP, OP_CORD_STEP, OP_SQRT_STEP:
                    cnt_reg <= cnt_reg + 6'd1;
                OP_COMMIT:
                begin
                    out_valid_reg    <= 1'b1;
                    anchor_reg       <= !marker_ready_reg;
                    marker_ready_reg <= 1'b1;
                    speed_reg        <= v_new_reg;
                    turn_reg         <= w_new_reg;
                    heading_reg      <= th_new_reg;
                    posx_reg         <= posx_new_reg;
                    posy_reg         <= posy_new_reg;
                    mkx_reg          <= mx_reg;
                    mky_reg          <= my_reg;
                    if (marker_ready_reg)
                        path_reg <= path_next;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cmd_v_reg <= cmd_speed;
                cmd_w_reg <= cmd_turn;
            end
            OP_DIV_LIMV, OP_DIV_LIMW, OP_DIV_DTH, OP_DIV_DXY:
            begin
                dq_reg  <= num_u;
                neg_reg <= num_s[32];
            end
            OP_DIV_STEP:
                dq_reg <= 32'(div_prod >> DIV_SHIFT);
            OP_SET_V:   v_new_reg  <= v_next;
            OP_SET_W:   w_new_reg  <= w_next;
            OP_SET_DTH:
            begin
                dth_reg    <= dth_next;
                th_new_reg <= th_next;
            end
            OP_SET_DXY: dxy_reg <= quot_s[20:0];
            OP_CORD_MID, OP_CORD_MARK:
            begin
                cx_reg   <= 34'(CORDIC_K);
                cy_reg   <= '0;
                cz_reg   <= z_init;
                flip_reg <= flip_init;
            end
            OP_CORD_STEP:
            begin
                if (cz_reg >= 0)
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - at_v;
                end
                else
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + at_v;
                end
            end
            OP_MUL_XC, OP_MUL_YS, OP_MUL_MXC, OP_MUL_MYS, OP_MUL_AX, OP_MUL_AY:
                prod_reg <= 64'(ma * mb);
            OP_POSX: posx_new_reg <= sat32(35'(posx_reg) + 35'(mq30));
            OP_POSY: posy_new_reg <= sat32(35'(posy_reg) + 35'(mq30));
            OP_MX:   mx_reg <= sat32(35'(posx_new_reg) + 35'(mq30));
            OP_MY:   my_reg <= sat32(35'(posy_new_reg) + 35'(mq30));
            OP_DIFF:
            begin
                ax_reg    <= big ? adx[31:1] : adx[30:0];
                ay_reg    <= big ? ady[31:1] : ady[30:0];
                halve_reg <= big;
            end
            OP_SQX: sq_reg <= prod_reg[62:0];
            OP_SQ_SUM:
            begin
                sv_reg   <= {1'b0, sq_reg} + {1'b0, prod_reg[62:0]};
                sr_reg   <= '0;
                sbit_reg <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT_STEP:
            begin
                if (sv_reg >= s_trial)
                begin
                    sv_reg <= sv_reg - s_trial;
                    sr_reg <= (sr_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            default: ;
        endcase
    end

    assign status.started      = started_reg;
    assign status.marker_ready = marker_ready_reg;
    assign status.div_done     = (cnt_reg == 6'(DIV_STEPS));
    assign status.cord_done    = (cnt_reg == 6'(CORDIC_N));
    assign status.sqrt_done    = (cnt_reg == 6'(SQRT_STEPS));
    assign status.out_busy     = out_valid_reg && out_stall;

    assign out_valid     = out_valid_reg;
    assign pos_x         = posx_reg;
    assign pos_y         = posy_reg;
    assign heading_out   = heading_reg;
    assign speed_out     = speed_reg;
    assign turn_out      = turn_reg;
    assign marker_x_out  = mkx_reg;
    assign marker_y_out  = mky_reg;
    assign path_dist_out = path_reg;
    assign anchor        = anchor_reg;

endmodule
`default_nettype wire

FILE: rtl/core/unicycle_odometry_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unicycle_odometry_step
// Rate-limited unicycle odometry with a virtual marker and path length.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, cmd_speed, cmd_turn) carries one
// time step per transaction. The output channel (out_valid, out_stall and
// the result fields) carries the updated pose, marker and path length.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while the block is idle.
// The first transaction after reset only arms the block and produces no
// result. Every later transaction produces one result, computed by four
// reciprocal-multiply divisions by 1000, two 16-step CORDIC passes and,
// once the path length is being accumulated, a 32-step square root, all
// run in sequence on shared units. One transaction is processed at a
// time; in_stall is high from the cycle after acceptance until the
// result is stored.
// Reset clears the pose, rate, marker and path registers and loads the
// default configuration. A stalled result holds its fields; the next item
// may be accepted meanwhile, but its result is held back until the previous one has been taken.
// ----------------------------------------------------------------------------
module unicycle_odometry_step (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [15:0]  cmd_speed,
    input  wire logic signed [15:0]  cmd_turn,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [31:0]       pos_x,
    output logic signed [31:0]       pos_y,
    output logic signed [15:0]       heading_out,
    output logic signed [15:0]       speed_out,
    output logic signed [15:0]       turn_out,
    output logic signed [31:0]       marker_x_out,
    output logic signed [31:0]       marker_y_out,
    output logic [31:0]              path_dist_out,
    output logic                     anchor,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import uos_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    uos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    uos_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd_speed     (cmd_speed),
        .cmd_turn      (cmd_turn),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading_out   (heading_out),
        .speed_out     (speed_out),
        .turn_out      (turn_out),
        .marker_x_out  (marker_x_out),
        .marker_y_out  (marker_y_out),
        .path_dist_out (path_dist_out),
        .anchor        (anchor)
    );

`ifndef SYNTHESIS
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a transaction in progress");

    a_anchor_no_path: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && anchor) |-> (path_dist_out == 32'd0))
        else $error("path length nonzero on the anchor result");

    a_heading_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_out <= 16'sd25736 && heading_out > -16'sd25736))
        else $error("heading outside the wrapped range");
`endif

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Unicycle odometry step testbench
// Drives time steps through the odometry block under several register
// settings, with bursty input traffic and random output stalls. A scoreboard
// predicts pose, rates, marker and path length and checks every result.
// ----------------------------------------------------------------------------
module testbench;
    import uos_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] speed;
        logic signed [15:0] turn;
        logic signed [31:0] marker_x;
        logic signed [31:0] marker_y;
        logic [31:0]        path_dist;
        logic               anchor;
    } odo_result_t;

    class odometry_scoreboard;
        longint step_ms, accel, ang_accel, speed_lim, turn_lim, mdist;
        logic [15:0] mhead;
        bit started, marker_ready;
        longint speed, turn, heading, px, py, mx_old, my_old;
        longint unsigned path;
        odo_result_t pose_q[$];
        int errors;

        function new();
            step_ms = 100; accel = 1229; ang_accel = 6144;
            speed_lim = 3072; turn_lim = 4096; mdist = 0; mhead = 0;
            started = 0; marker_ready = 0;
            speed = 0; turn = 0; heading = 0;
            px = 0; py = 0; mx_old = 0; my_old = 0; path = 0;
            errors = 0;
        endfunction

        function void write_register(cfg_idx_t idx, logic [15:0] d);
            case (idx)
                CFG_STEP_MS:   step_ms = longint'(d[9:0]);
                CFG_ACCEL:     accel = longint'(d[14:0]);
                CFG_ANG_ACCEL: ang_accel = longint'(d[14:0]);
                CFG_SPEED_LIM: speed_lim = longint'(d[14:0]);
                CFG_TURN_LIM:  turn_lim = longint'(d[14:0]);
                CFG_MDIST:     mdist = longint'(d[14:0]);
                CFG_MHEAD:     mhead = d;
                default: ;
            endcase
        endfunction

        function longint div_round(longint n, longint d);
            return n >= 0 ? (n + d / 2) / d : -((-n + d / 2) / d);
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint sat32(longint v);
            return clamp(v, -64'sd2147483648, 64'sd2147483647);
        endfunction

        function void cordic_rotate(longint ang, output longint c, output longint s);
            longint x, y, z, t;
            bit flip;
            x = CORDIC_K; y = 0; z = ang; flip = 0;
            while (z > PI_A) z -= TWO_PI_A;
            while (z <= -PI_A) z += TWO_PI_A;
            if (z > HALF_PI_A) begin z -= PI_A; flip = 1; end
            else if (z < -HALF_PI_A) begin z += PI_A; flip = 1; end
            for (int i = 0; i < CORDIC_N; i++) begin
                if (z >= 0) begin
                    t = x - (y >>> i); y = y + (x >>> i); z -= longint'(atan_val(4'(i)));
                end else begin
                    t = x + (y >>> i); y = y - (x >>> i); z += longint'(atan_val(4'(i)));
                end
                x = t;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint scale_q30(longint a, longint q);
            return (a * q + (64'sd1 << 29)) >>> 30;
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
                else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function void note_input(logic signed [15:0] cs, logic signed [15:0] ct);
            longint lim, v, w, dth, th, dxy, c, s, md, mx, my, dx, dy;
            longint unsigned ax, ay, stp;
            odo_result_t r;
            if (!started) begin
                started = 1;
                return;
            end
            lim = div_round(accel * step_ms, 1000);
            v = clamp(speed + clamp(longint'(cs) - speed, -lim, lim), -speed_lim, speed_lim);
            lim = div_round(ang_accel * step_ms, 1000);
            w = clamp(turn + clamp(longint'(ct) - turn, -lim, lim), -turn_lim, turn_lim);
            dth = div_round((turn + w) * step_ms, 1000);
            th = heading + dth;
            while (th > PI_Q13) th -= TWO_PI_Q13;
            while (th <= -PI_Q13) th += TWO_PI_Q13;
            dxy = div_round((speed + v) * 8 * step_ms, 1000);
            cordic_rotate(heading * 8 + dth * 4, c, s);
            px = sat32(px + scale_q30(dxy, c));
            py = sat32(py + scale_q30(dxy, s));
            md = mdist * 16;
            cordic_rotate((th + longint'($signed(mhead))) * 8, c, s);
            mx = sat32(px + scale_q30(md, c));
            my = sat32(py + scale_q30(md, s));
            r.anchor = 0;
            if (!marker_ready) begin
                marker_ready = 1;
                r.anchor = 1;
            end else begin
                dx = mx - mx_old; dy = my - my_old;
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
                    ax >>= 1; ay >>= 1;
                    stp = isqrt(ax * ax + ay * ay) * 2;
                end else begin
                    stp = isqrt(ax * ax + ay * ay);
                end
                path = path + stp;
                if (path > 64'hFFFF_FFFF) path = 64'hFFFF_FFFF;
            end
            speed = v; turn = w; heading = th; mx_old = mx; my_old = my;
            r.pos_x = 32'(px); r.pos_y = 32'(py); r.heading = 16'(th);
            r.speed = 16'(v); r.turn = 16'(w);
            r.marker_x = 32'(mx); r.marker_y = 32'(my); r.path_dist = 32'(path);
            pose_q.push_back(r);
        endfunction

        function void compare(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(odo_result_t a);
            odo_result_t e;
            if (pose_q.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pose_q.pop_front();
            compare("pos_x", e.pos_x, a.pos_x);
            compare("pos_y", e.pos_y, a.pos_y);
            compare("heading_out", e.heading, a.heading);
            compare("speed_out", e.speed, a.speed);
            compare("turn_out", e.turn, a.turn);
            compare("marker_x_out", e.marker_x, a.marker_x);
            compare("marker_y_out", e.marker_y, a.marker_y);
            compare("path_dist_out", e.path_dist, a.path_dist);
            compare("anchor", e.anchor, a.anchor);
        endfunction
    endclass

    logic clk = 0;
    logic rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic signed [15:0] cmd_speed, cmd_turn;
    logic signed [31:0] pos_x, pos_y, marker_x_out, marker_y_out;
    logic signed [15:0] heading_out, speed_out, turn_out;
    logic [31:0] path_dist_out;
    logic anchor;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    odometry_scoreboard sb = new();
    int quiet;
    int stall_run, stall_mode;

    always #5 clk = ~clk;

    unicycle_odometry_step DUT (.*);

    always @(posedge clk) begin
        odo_result_t a;
        quiet++;
        if (rst_n && out_valid && !out_stall) begin
            a.pos_x = pos_x; a.pos_y = pos_y; a.heading = heading_out;
            a.speed = speed_out; a.turn = turn_out; a.marker_x = marker_x_out;
            a.marker_y = marker_y_out; a.path_dist = path_dist_out; a.anchor = anchor;
            sb.check_result(a);
            quiet = 0;
        end
        if (stall_run == 0) begin
            stall_run = $urandom_range(1, 40);
            stall_mode = $urandom_range(0, 3);
        end
        stall_run--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= 1'b1;
            default: out_stall <= ~out_stall;
        endcase
        if (quiet > QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_step(logic signed [15:0] s, logic signed [15:0] t);
        in_valid <= 1'b1;
        cmd_speed <= s;
        cmd_turn <= t;
        do @(posedge clk); while (in_stall);
        sb.note_input(s, t);
        quiet = 0;
    endtask

    task automatic hold_off(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx, d);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pose_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_cmd();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [15:0] v [7];
        int burst;
        rst_n = 0;
        in_valid = 0; cmd_speed = 0; cmd_turn = 0; out_stall = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        quiet = 0; stall_run = 0; stall_mode = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_step(16'sh7FFF, 16'sh7FFF);
        send_step(16'sh7FFF, 16'sh7FFF);
        send_step(16'sh8000, 16'sh8000);
        send_step(16'sh8000, 16'sh7FFF);
        send_step(16'sh0000, 16'sh0000);
        hold_off(3);
        send_step(16'sh1000, 16'shF000);
        send_step(16'sh7FFF, 16'sh8000);
        drain();

        for (int p = 0; p < 10; p++) begin
            for (int i = 0; i < 7; i++) v[i] = 16'($urandom());
            v[0] = 16'($urandom_range(1, 1000));
            case (p)
                0: v = '{16'h03FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF};
                1: v = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000};
                2: v = '{16'd1, 16'd32767, 16'd32767, 16'd32767, 16'd32767, 16'd32767, -16'sd25736};
                3: v = '{16'd1000, 16'd32767, 16'd32767, 16'd32767, 16'd32767, 16'd4096, 16'sd25736};
                4: v = '{16'd100, 16'd1229, 16'd6144, 16'd3072, 16'd4096, 16'd2048, 16'd0};
                default: ;
            endcase
            write_cfg(CFG_STEP_MS, v[0]);
            write_cfg(CFG_ACCEL, v[1]);
            write_cfg(CFG_ANG_ACCEL, v[2]);
            write_cfg(CFG_SPEED_LIM, v[3]);
            write_cfg(CFG_TURN_LIM, v[4]);
            write_cfg(CFG_MDIST, v[5]);
            write_cfg(CFG_MHEAD, v[6]);
            cfg_valid <= 1'b0;
            if (p == 0) begin
                send_step(16'sh7FFF, 16'sh7FFF);
                send_step(16'sh8000, 16'sh8000);
                send_step(16'sh7FFF, 16'sh8000);
            end
            for (int n = 0; n < 100; n += burst) begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst; k++) send_step(pick_cmd(), pick_cmd());
                case ($urandom_range(0, 7))
                    0: drain();
                    1, 2: hold_off($urandom_range(1, 250));
                    3, 4, 5: hold_off($urandom_range(1, 20));
                    default: ;
                endcase
            end
            drain();
        end

        if (sb.errors == 0 && sb.pose_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/uos_pkg.sv
rtl/core/uos_ctrl.sv
rtl/core/uos_datapath.sv
rtl/core/unicycle_odometry_step.sv
dv/testbench.sv
